// ----- sv/vva_pkg.sv -----
// Shared types, constants and arithmetic helpers for the velocity Verlet atom update.
// Depends on nothing; every other file of the block imports it.
package vva_pkg;

   localparam int VAL_W        = 32;
   localparam int FRAC_W       = 16;
   localparam int IDX_W        = 10;
   localparam int PROD_W       = 2 * VAL_W;
   localparam int DIV_STAGES   = PROD_W;
   localparam int AXIS_PRE     = 3;
   localparam int AXIS_POST    = 7;
   localparam int AXIS_LATENCY = AXIS_PRE + DIV_STAGES + AXIS_POST;
   localparam int FRONT_STAGES = 4;
   localparam int RSP_LATENCY  = FRONT_STAGES + AXIS_LATENCY;

   localparam logic [VAL_W-1:0]        STEP_RESET = 32'd655;
   localparam logic signed [VAL_W-1:0] VAL_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN    = 32'sh8000_0000;

   localparam logic ACT_FIRST = 1'b0;
   localparam logic ACT_INTEG = 1'b1;

   typedef struct packed {
      logic                    action;
      logic [IDX_W-1:0]        atom_index;
      logic [VAL_W-1:0]        atom_mass;
      logic signed [VAL_W-1:0] pos_x;
      logic signed [VAL_W-1:0] pos_y;
      logic signed [VAL_W-1:0] pos_z;
      logic signed [VAL_W-1:0] vel_x;
      logic signed [VAL_W-1:0] vel_y;
      logic signed [VAL_W-1:0] vel_z;
      logic signed [VAL_W-1:0] force_x;
      logic signed [VAL_W-1:0] force_y;
      logic signed [VAL_W-1:0] force_z;
   } req_word_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_index;
      logic signed [VAL_W-1:0] new_pos_x;
      logic signed [VAL_W-1:0] new_pos_y;
      logic signed [VAL_W-1:0] new_pos_z;
      logic signed [VAL_W-1:0] new_vel_x;
      logic signed [VAL_W-1:0] new_vel_y;
      logic signed [VAL_W-1:0] new_vel_z;
   } rsp_word_type;

   // Apply a sign to a magnitude, clamp to the signed value range.
   function automatic logic signed [VAL_W-1:0] sat_pack(input logic neg,
                                                        input logic [PROD_W-1:0] mag);
      logic signed [VAL_W-1:0] low;
      low = signed'(mag[VAL_W-1:0]);
      if (mag > PROD_W'(VAL_MAX)) begin
         return neg ? VAL_MIN : VAL_MAX;
      end
      return neg ? -low : low;
   endfunction

   function automatic logic signed [VAL_W-1:0] clamp_add(input logic signed [VAL_W-1:0] a,
                                                         input logic signed [VAL_W-1:0] b);
      logic signed [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1]) begin
         return s[VAL_W] ? VAL_MIN : VAL_MAX;
      end
      return s[VAL_W-1:0];
   endfunction

   function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] x);
      return x[VAL_W-1] ? VAL_W'(-x) : VAL_W'(x);
   endfunction

endpackage

// ----- sv/vva_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vva_pkg for widths.
module vva_divider import vva_pkg::*; (
   input  logic              clock,
   input  logic [PROD_W-1:0] dividend,
   input  logic [VAL_W-1:0]  divisor,
   output logic [PROD_W-1:0] quotient
);

   logic [VAL_W-1:0]  a_ff [DIV_STAGES];
   logic [PROD_W-1:0] q_ff [DIV_STAGES];
   logic [VAL_W-1:0]  d_ff [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
      logic [VAL_W-1:0]  a_src;
      logic [PROD_W-1:0] q_src;
      logic [VAL_W-1:0]  d_src;
      logic [VAL_W:0]    trial;

      if (g == 0) begin : g_first
         assign a_src = '0;
         assign q_src = dividend;
         assign d_src = divisor;
      end else begin : g_next
         assign a_src = a_ff[g-1];
         assign q_src = q_ff[g-1];
         assign d_src = d_ff[g-1];
      end

      assign trial = {a_src, q_src[PROD_W-1]};

      always_ff @(posedge clock) begin
         if (trial >= {1'b0, d_src}) begin
            a_ff[g] <= VAL_W'(trial - {1'b0, d_src});
            q_ff[g] <= {q_src[PROD_W-2:0], 1'b1};
         end else begin
            a_ff[g] <= trial[VAL_W-1:0];
            q_ff[g] <= {q_src[PROD_W-2:0], 1'b0};
         end
         d_ff[g] <= d_src;
      end
   end

   assign quotient = q_ff[DIV_STAGES-1];

endmodule

// ----- sv/vva_axis.sv -----
// One axis of the Verlet update: kick, drift and saturating adds, fully pipelined.
// Depends on vva_pkg and vva_divider.
module vva_axis import vva_pkg::*; (
   input  logic                    clock,
   input  logic signed [VAL_W-1:0] pos_i,
   input  logic signed [VAL_W-1:0] vel_i,
   input  logic signed [VAL_W-1:0] frc_i,
   input  logic signed [VAL_W-1:0] prev_i,
   input  logic [VAL_W-1:0]        mass_i,
   input  logic [VAL_W-1:0]        step_i,
   input  logic                    integ_i,
   output logic signed [VAL_W-1:0] new_pos_o,
   output logic signed [VAL_W-1:0] new_vel_o
);

   typedef struct packed {
      logic signed [VAL_W-1:0] p;
      logic signed [VAL_W-1:0] v;
      logic                    integ;
      logic                    fneg;
      logic                    sneg;
   } ctx_type;

   // front: force sum, magnitudes, products
   logic signed [VAL_W:0]   fs1_ff;
   logic signed [VAL_W-1:0] f1_ff, p1_ff, v1_ff;
   logic [VAL_W-1:0]        m1_ff;
   logic                    integ1_ff;

   logic [VAL_W:0]          fsmag2_ff;
   logic [VAL_W-1:0]        fmag2_ff, m2_ff;
   logic                    sneg2_ff, fneg2_ff, integ2_ff;
   logic signed [VAL_W-1:0] p2_ff, v2_ff;

   logic [PROD_W:0]         ps_full;
   logic [PROD_W-1:0]       pf3_ff, ps3_ff;
   logic [VAL_W-1:0]        m3_ff;
   ctx_type                 ctx3_ff;

   logic [PROD_W-1:0]       qf, qs;
   ctx_type                 ctx_dly_ff [DIV_STAGES];

   // back: velocity kick, drift and position kick
   logic signed [VAL_W-1:0] dv4_ff;
   logic [PROD_W-2:0]       kq4_ff;
   ctx_type                 ctx4_ff;

   logic signed [VAL_W-1:0] vnew5_ff, p5_ff;
   logic [PROD_W-1:0]       kplo5_ff;
   logic [46:0]             kphi5_ff;
   logic                    khuge5_ff, fneg5_ff;

   logic [VAL_W-1:0]        vmag6_ff;
   logic                    vneg6_ff, khuge6_ff, fneg6_ff;
   logic signed [VAL_W-1:0] vnew6_ff, p6_ff;
   logic [78:0]             ksum6_ff;

   logic [PROD_W-1:0]       dprod7_ff;
   logic signed [VAL_W-1:0] kick7_ff, vnew7_ff, p7_ff;
   logic                    vneg7_ff;

   logic signed [VAL_W-1:0] drift8_ff, kick8_ff, vnew8_ff, p8_ff;
   logic signed [VAL_W-1:0] np9_ff, kick9_ff, vnew9_ff;
   logic signed [VAL_W-1:0] new_pos_ff, new_vel_ff;

   assign ps_full = fsmag2_ff * step_i;

   always_ff @(posedge clock) begin
      fs1_ff    <= {frc_i[VAL_W-1], frc_i} + {prev_i[VAL_W-1], prev_i};
      f1_ff     <= frc_i;
      p1_ff     <= pos_i;
      v1_ff     <= vel_i;
      m1_ff     <= mass_i;
      integ1_ff <= integ_i;

      sneg2_ff  <= fs1_ff[VAL_W];
      fsmag2_ff <= fs1_ff[VAL_W] ? (VAL_W+1)'(-fs1_ff) : (VAL_W+1)'(fs1_ff);
      fneg2_ff  <= f1_ff[VAL_W-1];
      fmag2_ff  <= mag32(f1_ff);
      p2_ff     <= p1_ff;
      v2_ff     <= v1_ff;
      m2_ff     <= m1_ff;
      integ2_ff <= integ1_ff;

      pf3_ff        <= fmag2_ff * step_i;
      ps3_ff        <= ps_full[PROD_W-1:0];
      m3_ff         <= m2_ff;
      ctx3_ff.p     <= p2_ff;
      ctx3_ff.v     <= v2_ff;
      ctx3_ff.integ <= integ2_ff;
      ctx3_ff.fneg  <= fneg2_ff;
      ctx3_ff.sneg  <= sneg2_ff;
   end

   vva_divider u_div_kick (
      .clock    (clock),
      .dividend (pf3_ff),
      .divisor  (m3_ff),
      .quotient (qf)
   );

   vva_divider u_div_vel (
      .clock    (clock),
      .dividend (ps3_ff),
      .divisor  (m3_ff),
      .quotient (qs)
   );

   // hold the context alongside the dividers
   always_ff @(posedge clock) begin
      ctx_dly_ff[0] <= ctx3_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         ctx_dly_ff[i] <= ctx_dly_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      dv4_ff  <= sat_pack(ctx_dly_ff[DIV_STAGES-1].sneg, {1'b0, qs[PROD_W-1:1]});
      kq4_ff  <= qf[PROD_W-1:1];
      ctx4_ff <= ctx_dly_ff[DIV_STAGES-1];

      vnew5_ff  <= ctx4_ff.integ ? clamp_add(ctx4_ff.v, dv4_ff) : ctx4_ff.v;
      kplo5_ff  <= kq4_ff[31:0] * step_i;
      kphi5_ff  <= kq4_ff[46:32] * step_i;
      khuge5_ff <= (kq4_ff[62:47] != '0) && (step_i != '0);
      p5_ff     <= ctx4_ff.p;
      fneg5_ff  <= ctx4_ff.fneg;

      vmag6_ff  <= mag32(vnew5_ff);
      vneg6_ff  <= vnew5_ff[VAL_W-1];
      vnew6_ff  <= vnew5_ff;
      ksum6_ff  <= 79'(kplo5_ff) + {kphi5_ff, 32'b0};
      khuge6_ff <= khuge5_ff;
      fneg6_ff  <= fneg5_ff;
      p6_ff     <= p5_ff;

      dprod7_ff <= vmag6_ff * step_i;
      kick7_ff  <= sat_pack(fneg6_ff, khuge6_ff ? '1 : {1'b0, ksum6_ff[78:FRAC_W]});
      vneg7_ff  <= vneg6_ff;
      vnew7_ff  <= vnew6_ff;
      p7_ff     <= p6_ff;

      drift8_ff <= sat_pack(vneg7_ff, {{FRAC_W{1'b0}}, dprod7_ff[PROD_W-1:FRAC_W]});
      kick8_ff  <= kick7_ff;
      vnew8_ff  <= vnew7_ff;
      p8_ff     <= p7_ff;

      np9_ff    <= clamp_add(p8_ff, drift8_ff);
      kick9_ff  <= kick8_ff;
      vnew9_ff  <= vnew8_ff;

      new_pos_ff <= clamp_add(np9_ff, kick9_ff);
      new_vel_ff <= vnew9_ff;
   end

   assign new_pos_o = new_pos_ff;
   assign new_vel_o = new_vel_ff;

endmodule

// ----- sv/velocity_verlet_atom_update.sv -----
// Velocity Verlet atom update, top level. An accepted word passes through
// 4 front stages and 74 per-axis stages, dominated by the 64-stage pipelined
// dividers, on its way to rsp_word. Throughput: one word every cycle.
// Reset clears the step size to 655 and all valid bits; the per-atom force
// store is not cleared. busy is high only during reset; rsp cannot be stalled.
module velocity_verlet_atom_update import vva_pkg::*; #(
   parameter int MAX_ATOMS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_word_type       req_word,
   output logic               rsp_strobe,
   output rsp_word_type       rsp_word,
   input  logic               csr_wr_en,
   input  logic [VAL_W-1:0]   csr_wr_data
);

   localparam int SLOT_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int HALF   = IDX_W / 2;

   // step size register
   logic [VAL_W-1:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   // no backpressure: take a word every cycle outside reset
   assign busy = reset;

   // front stages: capture, reduce index modulo the store depth, read force store
   logic             vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   req_word_type     item1_ff, item2_ff, item3_ff, item4_ff;
   logic [IDX_W-1:0] slot2_in, slot2_ff, slot3_in, slot3_ff;
   logic [VAL_W-1:0] mass4_ff;
   logic [3*VAL_W-1:0] prev_ff;
   logic [3*VAL_W-1:0] frc_mem [MAX_ATOMS];

   // upper half of the conditional-subtract reduction
   always_comb begin
      slot2_in = item1_ff.atom_index;
      for (int k = IDX_W - 1; k >= HALF; k--) begin
         if (32'(slot2_in) >= (MAX_ATOMS << k)) begin
            slot2_in = slot2_in - IDX_W'(MAX_ATOMS << k);
         end
      end
   end

   // lower half
   always_comb begin
      slot3_in = slot2_ff;
      for (int k = HALF - 1; k >= 0; k--) begin
         if (32'(slot3_in) >= (MAX_ATOMS << k)) begin
            slot3_in = slot3_in - IDX_W'(MAX_ATOMS << k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         vld1_ff <= start && !busy;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      item1_ff <= req_word;
      item2_ff <= item1_ff;
      slot2_ff <= slot2_in;
      item3_ff <= item2_ff;
      slot3_ff <= slot3_in;
      item4_ff <= item3_ff;
      // zero mass acts as the smallest mass
      mass4_ff <= (item3_ff.atom_mass == '0) ? VAL_W'(1) : item3_ff.atom_mass;
   end

   // read the last force and write the current one in the same stage, so the
   // next word for the same atom already sees this write
   always_ff @(posedge clock) begin
      prev_ff <= frc_mem[SLOT_W'(slot3_ff)];
      if (vld3_ff) begin
         frc_mem[SLOT_W'(slot3_ff)] <= {item3_ff.force_z, item3_ff.force_y, item3_ff.force_x};
      end
   end

   // per-axis datapaths
   logic integ4;
   rsp_word_type rsp_in;

   assign integ4 = (item4_ff.action == ACT_INTEG);

   vva_axis u_axis_x (
      .clock     (clock),
      .pos_i     (item4_ff.pos_x),
      .vel_i     (item4_ff.vel_x),
      .frc_i     (item4_ff.force_x),
      .prev_i    (signed'(prev_ff[VAL_W-1:0])),
      .mass_i    (mass4_ff),
      .step_i    (step_ff),
      .integ_i   (integ4),
      .new_pos_o (rsp_in.new_pos_x),
      .new_vel_o (rsp_in.new_vel_x)
   );

   vva_axis u_axis_y (
      .clock     (clock),
      .pos_i     (item4_ff.pos_y),
      .vel_i     (item4_ff.vel_y),
      .frc_i     (item4_ff.force_y),
      .prev_i    (signed'(prev_ff[2*VAL_W-1:VAL_W])),
      .mass_i    (mass4_ff),
      .step_i    (step_ff),
      .integ_i   (integ4),
      .new_pos_o (rsp_in.new_pos_y),
      .new_vel_o (rsp_in.new_vel_y)
   );

   vva_axis u_axis_z (
      .clock     (clock),
      .pos_i     (item4_ff.pos_z),
      .vel_i     (item4_ff.vel_z),
      .frc_i     (item4_ff.force_z),
      .prev_i    (signed'(prev_ff[3*VAL_W-1:2*VAL_W])),
      .mass_i    (mass4_ff),
      .step_i    (step_ff),
      .integ_i   (integ4),
      .new_pos_o (rsp_in.new_pos_z),
      .new_vel_o (rsp_in.new_vel_z)
   );

   // advance valid and index alongside the axis pipelines
   logic             vld_dly_ff [AXIS_LATENCY];
   logic [IDX_W-1:0] idx_dly_ff [AXIS_LATENCY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXIS_LATENCY; i++) begin
            vld_dly_ff[i] <= 1'b0;
         end
      end else begin
         vld_dly_ff[0] <= vld4_ff;
         for (int i = 1; i < AXIS_LATENCY; i++) begin
            vld_dly_ff[i] <= vld_dly_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_dly_ff[0] <= item4_ff.atom_index;
      for (int i = 1; i < AXIS_LATENCY; i++) begin
         idx_dly_ff[i] <= idx_dly_ff[i-1];
      end
   end

   assign rsp_in.out_index = idx_dly_ff[AXIS_LATENCY-1];

   assign rsp_strobe = vld_dly_ff[AXIS_LATENCY-1];
   assign rsp_word   = rsp_in;

endmodule

// ----- sv/vva_checker.sv -----
// Port-level checks for the velocity Verlet atom update, bound to the top level.
// Depends on vva_pkg for the latency and action codes.
module vva_checker import vva_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input req_word_type     req_word,
   input logic             rsp_strobe,
   input rsp_word_type     rsp_word,
   input logic             csr_wr_en,
   input logic [VAL_W-1:0] csr_wr_data
);

   logic accept;
   assign accept = start && !busy;

   // every accepted word comes back after the fixed latency with its index
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##RSP_LATENCY
         (rsp_strobe && rsp_word.out_index == $past(req_word.atom_index, RSP_LATENCY)))
      else $error("accepted word did not return with its index");

   // no result without a word accepted one latency earlier
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, RSP_LATENCY))
      else $error("result strobe without an accepted word");

   // first-step words pass velocity through
   a_first_vel: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.action == ACT_FIRST) |-> ##RSP_LATENCY
         (rsp_word.new_vel_x == $past(req_word.vel_x, RSP_LATENCY) &&
          rsp_word.new_vel_y == $past(req_word.vel_y, RSP_LATENCY) &&
          rsp_word.new_vel_z == $past(req_word.vel_z, RSP_LATENCY)))
      else $error("first-step velocity changed");

   // configuration writes that change the value only in cycles where no word is accepted
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && $past(csr_wr_data) != csr_wr_data) |-> !accept || !csr_wr_en)
      else $error("configuration written while a word is accepted");

endmodule

bind velocity_verlet_atom_update vva_checker u_vva_checker (.*);

// ----- test/velocity_verlet_atom_update_test.sv -----
// Self-checking testbench for the velocity Verlet atom update block.
// Depends on vva_pkg and velocity_verlet_atom_update; predicts each result word in-line.
`timescale 1ns / 1ps

module velocity_verlet_atom_update_test;
   import vva_pkg::*;

   localparam int  ATOM_COUNT  = 1024;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  RAND_ITEMS  = 150;
   localparam longint SAT_HI   = 64'sd2147483647;
   localparam longint SAT_LO   = -64'sd2147483648;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_word_type       req_word = '0;
   logic               rsp_strobe;
   rsp_word_type       rsp_word;
   logic               csr_wr_en = 1'b0;
   logic [VAL_W-1:0]   csr_wr_data = '0;

   velocity_verlet_atom_update dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: our own copy of the step size and the per-atom last force.
   logic [63:0]  step_dt = 64'(STEP_RESET);
   longint       prior_force [3][ATOM_COUNT];

   req_word_type pending_atoms [$];
   rsp_word_type expected_updates [$];
   bit           force_known [ATOM_COUNT];
   int           words_sent = 0;
   int           words_checked = 0;
   int           mismatches = 0;
   int           cycles = 0;
   int           integ_words = 0;
   bit           gaps_on = 1'b1;

   // ---------------------------------------------------------------------
   // Fixed-point arithmetic of the predictor
   // ---------------------------------------------------------------------
   function automatic longint clamp_val(longint x);
      if (x > SAT_HI) return SAT_HI;
      if (x < SAT_LO) return SAT_LO;
      return x;
   endfunction

   function automatic logic [63:0] magnitude(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   // Products above 64 bits hold at the 64-bit maximum.
   function automatic logic [63:0] mul_hold(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return (p[127:64] != 0) ? '1 : p[63:0];
   endfunction

   // Apply the sign, clamp the magnitude to the value range.
   function automatic longint signed_clamp(bit neg, logic [63:0] m);
      if (m > 64'h7FFF_FFFF) return neg ? SAT_LO : SAT_HI;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic void advance_axis(input bit integ, input longint p, input longint v,
                                        input longint f, input longint f_prev,
                                        input logic [63:0] dt, input logic [63:0] m,
                                        output longint p_new, output longint v_new);
      longint      fs;
      longint      dv;
      logic [63:0] q;
      v_new = v;
      if (integ) begin
         // Kick the velocity by the average of last and current force.
         fs = f + f_prev;
         dv = signed_clamp(fs < 0, (mul_hold(magnitude(fs), dt) / m) >> 1);
         v_new = clamp_val(v + dv);
      end
      p_new = clamp_val(p + signed_clamp(v_new < 0, mul_hold(magnitude(v_new), dt) >> FRAC_W));
      q = (mul_hold(magnitude(f), dt) / m) >> 1;
      p_new = clamp_val(p_new + signed_clamp(f < 0, mul_hold(q, dt) >> FRAC_W));
   endfunction

   // Work out the update of one atom and record its force for the next step.
   function automatic rsp_word_type predict_update(req_word_type w);
      rsp_word_type r;
      logic [63:0]  m;
      longint       p [3];
      longint       v [3];
      longint       f [3];
      longint       np [3];
      longint       nv [3];
      int           slot;
      bit           integ;
      p = '{longint'(w.pos_x), longint'(w.pos_y), longint'(w.pos_z)};
      v = '{longint'(w.vel_x), longint'(w.vel_y), longint'(w.vel_z)};
      f = '{longint'(w.force_x), longint'(w.force_y), longint'(w.force_z)};
      m = (w.atom_mass == 0) ? 64'd1 : 64'(w.atom_mass);
      slot = int'(w.atom_index) % ATOM_COUNT;
      integ = (w.action == ACT_INTEG);
      for (int a = 0; a < 3; a++) begin
         advance_axis(integ, p[a], v[a], f[a], prior_force[a][slot], step_dt, m, np[a], nv[a]);
         prior_force[a][slot] = f[a];
      end
      r.out_index = w.atom_index;
      r.new_pos_x = VAL_W'(np[0]);
      r.new_pos_y = VAL_W'(np[1]);
      r.new_pos_z = VAL_W'(np[2]);
      r.new_vel_x = VAL_W'(nv[0]);
      r.new_vel_y = VAL_W'(nv[1]);
      r.new_vel_z = VAL_W'(nv[2]);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return VAL_W'($urandom_range(0, 255)) * ($urandom_range(0, 1) ? -1 : 1);
         3: return VAL_W'($urandom_range(0, 1 << 20)) * ($urandom_range(0, 1) ? -1 : 1);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] pick_mass();
      case ($urandom_range(0, 5))
         0: return 32'd1;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 65535);
         3: return $urandom_range(1, 1 << 22);
         default: return $urandom | 32'd1;
      endcase
   endfunction

   function automatic void queue_atom(logic act, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] mass,
                                      logic [VAL_W-1:0] p, logic [VAL_W-1:0] v,
                                      logic [VAL_W-1:0] f);
      req_word_type w;
      w.action = act;
      w.atom_index = idx;
      w.atom_mass = mass;
      {w.pos_x, w.pos_y, w.pos_z} = {p, p ^ 32'h0000_FFFF, p};
      {w.vel_x, w.vel_y, w.vel_z} = {v, v, v ^ 32'h0000_0001};
      {w.force_x, w.force_y, w.force_z} = {f, -f, f};
      force_known[idx] = 1'b1;
      pending_atoms.push_back(w);
   endfunction

   // Random items: mostly valid sequences (first step then integrates) on a
   // small atom pool so integrate steps see recent forces; a share go anywhere.
   function automatic void queue_random(int count);
      req_word_type w;
      logic [IDX_W-1:0] idx;
      for (int n = 0; n < count; n++) begin
         idx = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 31)) : IDX_W'($urandom);
         w.atom_index = idx;
         w.action = (force_known[idx] && $urandom_range(0, 3) != 0) ? ACT_INTEG : ACT_FIRST;
         w.atom_mass = pick_mass();
         w.pos_x = pick_value();   w.pos_y = pick_value();   w.pos_z = pick_value();
         w.vel_x = pick_value();   w.vel_y = pick_value();   w.vel_z = pick_value();
         w.force_x = pick_value(); w.force_y = pick_value(); w.force_z = pick_value();
         force_known[idx] = 1'b1;
         pending_atoms.push_back(w);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present one word at a time, random gap drawn per word
   // ---------------------------------------------------------------------
   int gap_left = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            expected_updates.push_back(predict_update(req_word));
            words_sent++;
            if (req_word.action == ACT_INTEG) integ_words++;
         end
         // Hold the word while the block is busy; otherwise advance.
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_atoms.size() > 0) begin
               req_word <= pending_atoms.pop_front();
               start <= 1'b1;
               if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
               gap_left = gaps_on ? $urandom_range(0, 10) : 0;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each strobed word against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_updates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word at cycle %0d: %h", cycles, rsp_word);
         end else begin
            want = expected_updates.pop_front();
            words_checked++;
            if (rsp_word.out_index !== want.out_index ||
                rsp_word.new_pos_x !== want.new_pos_x || rsp_word.new_pos_y !== want.new_pos_y ||
                rsp_word.new_pos_z !== want.new_pos_z || rsp_word.new_vel_x !== want.new_vel_x ||
                rsp_word.new_vel_y !== want.new_vel_y || rsp_word.new_vel_z !== want.new_vel_z)
            begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at cycle %0d, atom %0d", cycles, want.out_index);
                  $display("  expected idx %0d pos %0d %0d %0d vel %0d %0d %0d", want.out_index,
                           want.new_pos_x, want.new_pos_y, want.new_pos_z,
                           want.new_vel_x, want.new_vel_y, want.new_vel_z);
                  $display("  actual   idx %0d pos %0d %0d %0d vel %0d %0d %0d",
                           rsp_word.out_index, rsp_word.new_pos_x, rsp_word.new_pos_y,
                           rsp_word.new_pos_z, rsp_word.new_vel_x, rsp_word.new_vel_y,
                           rsp_word.new_vel_z);
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Wait until every queued word went in and every update came back, then drain.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_atoms.size() > 0 || start || expected_updates.size() > 0);
      repeat (RSP_LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_step(logic [VAL_W-1:0] dt);
      csr_wr_en <= 1'b1;
      csr_wr_data <= dt;
      @(posedge clock);
      step_dt = 64'(dt);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   logic [VAL_W-1:0] step_plan [6] = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd1,
                                       32'h0000_4000, 32'd655};

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: zeros, field extremes, zero mass, integrate on both ends of the index range.
      queue_atom(ACT_FIRST, 10'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
      queue_atom(ACT_FIRST, 10'd1023, 32'd1, VAL_MAX, VAL_MAX, VAL_MAX);
      queue_atom(ACT_FIRST, 10'd512, 32'hFFFF_FFFF, VAL_MIN, VAL_MIN, VAL_MIN);
      queue_atom(ACT_FIRST, 10'd341, 32'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_0000);
      queue_atom(ACT_INTEG, 10'd0, 32'h0001_0000, 32'h0010_0000, 32'h0002_0000, 32'h0003_0000);
      queue_atom(ACT_INTEG, 10'd1023, 32'd1, VAL_MIN, VAL_MAX, VAL_MAX);
      queue_atom(ACT_INTEG, 10'd512, 32'd1, VAL_MAX, VAL_MIN, VAL_MIN);
      queue_atom(ACT_INTEG, 10'd341, 32'd0, 32'd0, 32'd0, 32'd0);
      queue_atom(ACT_INTEG, 10'd1023, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1);
      queue_atom(ACT_FIRST, 10'd682, 32'h0000_8000, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
      queue_atom(ACT_INTEG, 10'd682, 32'h0000_8000, 32'd1, 32'hFFFF_FFFF, 32'd1);
      queue_random(RAND_ITEMS);
      wait_drained();

      // Sweep the step size, including zero and the largest value.
      foreach (step_plan[i]) begin
         set_step(step_plan[i]);
         if (i == 4) set_step($urandom);
         queue_random(RAND_ITEMS);
         wait_drained();
      end

      $display("covered %0d atom words (%0d integrate steps), %0d checked, over %0d step sizes",
               words_sent, integ_words, words_checked, 8);
      if (mismatches == 0 && expected_updates.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
